@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle check
`define ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle check
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ rtl/crt_pkg.sv @@
`timescale 1ns / 1ps
package crt_pkg;
  localparam int MAX_EQ = 4;
  localparam int IDX_W  = 2;
  localparam int CNT_W  = 3;
  localparam int OP_W   = 5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_COPRIME = 2'd1;
  localparam logic [1:0] ST_ERR     = 2'd2;

  localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 5'd1;
  localparam logic [OP_W-1:0] OP_GINIT  = 5'd2;
  localparam logic [OP_W-1:0] OP_DIV_EU = 5'd3;
  localparam logic [OP_W-1:0] OP_EU_UPD = 5'd4;
  localparam logic [OP_W-1:0] OP_SINIT  = 5'd5;
  localparam logic [OP_W-1:0] OP_DIV_X  = 5'd6;
  localparam logic [OP_W-1:0] OP_SAVE_X = 5'd7;
  localparam logic [OP_W-1:0] OP_DIV_M  = 5'd8;
  localparam logic [OP_W-1:0] OP_IINIT  = 5'd9;
  localparam logic [OP_W-1:0] OP_DIV_A  = 5'd10;
  localparam logic [OP_W-1:0] OP_SAVE_A = 5'd11;
  localparam logic [OP_W-1:0] OP_DIV_T  = 5'd12;
  localparam logic [OP_W-1:0] OP_MINIT  = 5'd13;
  localparam logic [OP_W-1:0] OP_MSTEP  = 5'd14;
  localparam logic [OP_W-1:0] OP_MFIN   = 5'd15;
  localparam logic [OP_W-1:0] OP_OUT    = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx_i;
    logic [IDX_W-1:0] idx_j;
    logic [1:0]       status;
  } cmd_t;

  typedef struct packed {
    logic             div_done;
    logic             ovf;
    logic [CNT_W-1:0] cnt;
    logic             zmod;
    logic             rb_zero;
    logic             ra_one;
    logic             mul_done;
  } stat_t;
endpackage

@@ rtl/crt_div.sv @@
`timescale 1ns / 1ps
module crt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [63:0] quo,
  output logic [15:0] rem
);
  logic [63:0] dq_r, dq_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [16:0] sh;
  logic        qbit;

  // one quotient bit per cycle, restoring
  always_comb begin
    sh = {rem_r[15:0], dq_r[63]};
    qbit = (sh >= {1'b0, dvs_r});
    dq_nxt = dq_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = qbit ? (sh - {1'b0, dvs_r}) : sh;
      dq_nxt = {dq_r[62:0], qbit};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    dq_r <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo = dq_r;
  assign rem = rem_r[15:0];
endmodule

@@ rtl/crt_dp.sv @@
`timescale 1ns / 1ps
module crt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  crt_pkg::cmd_t       cmd,
  input  logic signed [31:0]  in_remainder,
  input  logic [15:0]         in_modulus,
  output crt_pkg::stat_t      stat,
  output logic                out_valid,
  output logic [63:0]         out_solution,
  output logic [63:0]         out_combined_modulus,
  output logic [1:0]          out_status
);
  logic [31:0] res_r [crt_pkg::MAX_EQ];
  logic [15:0] mod_r [crt_pkg::MAX_EQ];
  logic [crt_pkg::CNT_W-1:0] cnt_r;
  logic        ovf_r;
  logic [15:0] ra_r, rb_r, xr_r, ar_r, t_r, mm_r;
  logic signed [17:0] sa_r, sb_r;
  logic [63:0] x_r, m_r, pn_r, msh_r;
  logic        out_valid_r;
  logic [63:0] out_sol_r, out_comb_r;
  logic [1:0]  out_st_r;

  logic        div_start, div_done;
  logic [63:0] div_dividend, div_quo;
  logic [15:0] div_divisor, div_rem;
  logic [15:0] cur_mod, dmod, inv;
  logic [31:0] cur_res, mag, dt_prod;
  logic [17:0] inv_w;
  logic signed [34:0] qs;
  logic        ok;

  assign cur_mod = mod_r[cmd.idx_i];
  assign cur_res = res_r[cmd.idx_i];
  assign mag = cur_res[31] ? (~cur_res + 32'd1) : cur_res;
  assign dmod = ar_r - xr_r + ((ar_r < xr_r) ? cur_mod : 16'd0);
  assign inv_w = sa_r[17] ? (sa_r + $signed({2'b00, cur_mod})) : sa_r;
  assign inv = inv_w[15:0];
  assign dt_prod = dmod * inv;
  assign qs = $signed({1'b0, div_quo[15:0]}) * sb_r;
  assign ok = (cmd.status == crt_pkg::ST_OK);

  always_comb begin
    div_start = 1'b0;
    div_dividend = x_r;
    div_divisor = cur_mod;
    case (cmd.op)
      crt_pkg::OP_DIV_EU: begin
        div_start = 1'b1;
        div_dividend = {48'd0, ra_r};
        div_divisor = rb_r;
      end
      crt_pkg::OP_DIV_X: begin
        div_start = 1'b1;
      end
      crt_pkg::OP_DIV_M: begin
        div_start = 1'b1;
        div_dividend = m_r;
      end
      crt_pkg::OP_DIV_A: begin
        div_start = 1'b1;
        div_dividend = {32'd0, mag};
      end
      crt_pkg::OP_DIV_T: begin
        div_start = 1'b1;
        div_dividend = {32'd0, dt_prod};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  crt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == crt_pkg::OP_OUT);
      case (cmd.op)
        crt_pkg::OP_LOAD: begin
          if (cnt_r < crt_pkg::CNT_W'(crt_pkg::MAX_EQ)) begin
            res_r[cnt_r[crt_pkg::IDX_W-1:0]] <= in_remainder;
            mod_r[cnt_r[crt_pkg::IDX_W-1:0]] <= in_modulus;
            cnt_r <= cnt_r + 3'd1;
          end else begin
            ovf_r <= 1'b1;
          end
        end
        crt_pkg::OP_GINIT: begin
          ra_r <= mod_r[cmd.idx_i];
          rb_r <= mod_r[cmd.idx_j];
        end
        crt_pkg::OP_EU_UPD: begin
          ra_r <= rb_r;
          rb_r <= div_rem;
          sa_r <= sb_r;
          sb_r <= sa_r - qs[17:0];
        end
        crt_pkg::OP_SINIT: begin
          x_r <= '0;
          m_r <= 64'd1;
        end
        crt_pkg::OP_SAVE_X: begin
          xr_r <= div_rem;
        end
        crt_pkg::OP_IINIT: begin
          ra_r <= div_rem;
          rb_r <= cur_mod;
          sa_r <= 18'sd1;
          sb_r <= 18'sd0;
        end
        crt_pkg::OP_SAVE_A: begin
          ar_r <= (cur_res[31] && div_rem != 16'd0) ? (cur_mod - div_rem) : div_rem;
        end
        crt_pkg::OP_MINIT: begin
          t_r <= div_rem;
          mm_r <= cur_mod;
          msh_r <= m_r;
          pn_r <= '0;
        end
        crt_pkg::OP_MSTEP: begin
          if (t_r[0]) begin
            x_r <= x_r + msh_r;
          end
          if (mm_r[0]) begin
            pn_r <= pn_r + msh_r;
          end
          msh_r <= {msh_r[62:0], 1'b0};
          t_r <= {1'b0, t_r[15:1]};
          mm_r <= {1'b0, mm_r[15:1]};
        end
        crt_pkg::OP_MFIN: begin
          m_r <= pn_r;
        end
        crt_pkg::OP_OUT: begin
          out_st_r <= cmd.status;
          out_sol_r <= ok ? x_r : 64'd0;
          out_comb_r <= ok ? m_r : 64'd0;
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.div_done = div_done;
  assign stat.ovf = ovf_r;
  assign stat.cnt = cnt_r;
  assign stat.zmod = (cur_mod == 16'd0);
  assign stat.rb_zero = (rb_r == 16'd0);
  assign stat.ra_one = (ra_r == 16'd1);
  assign stat.mul_done = (t_r == 16'd0) && (mm_r == 16'd0);

  assign out_valid = out_valid_r;
  assign out_solution = out_sol_r;
  assign out_combined_modulus = out_comb_r;
  assign out_status = out_st_r;
endmodule

@@ rtl/crt_ctrl.sv @@
`timescale 1ns / 1ps
module crt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_last,
  input  crt_pkg::stat_t stat,
  output crt_pkg::cmd_t  cmd,
  output logic           busy
);
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHK   = 5'd1;
  localparam logic [4:0] S_ZCHK  = 5'd2;
  localparam logic [4:0] S_GINIT = 5'd3;
  localparam logic [4:0] S_GTEST = 5'd4;
  localparam logic [4:0] S_GWAIT = 5'd5;
  localparam logic [4:0] S_SINIT = 5'd6;
  localparam logic [4:0] S_XD    = 5'd7;
  localparam logic [4:0] S_XW    = 5'd8;
  localparam logic [4:0] S_MD    = 5'd9;
  localparam logic [4:0] S_MW    = 5'd10;
  localparam logic [4:0] S_AD    = 5'd11;
  localparam logic [4:0] S_AW    = 5'd12;
  localparam logic [4:0] S_ITEST = 5'd13;
  localparam logic [4:0] S_IW    = 5'd14;
  localparam logic [4:0] S_TW    = 5'd15;
  localparam logic [4:0] S_MS    = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic [crt_pkg::IDX_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [1:0] st_r, st_nxt;
  logic [crt_pkg::CNT_W-1:0] nl, iw, jw;

  assign nl = stat.cnt - 3'd1;
  assign iw = {1'b0, i_r};
  assign jw = {1'b0, j_r};

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    st_nxt = st_r;
    cmd.op = crt_pkg::OP_NOP;
    cmd.idx_i = i_r;
    cmd.idx_j = j_r;
    cmd.status = st_r;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op = crt_pkg::OP_LOAD;
          if (in_last) begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        i_nxt = '0;
        if (stat.ovf) begin
          st_nxt = crt_pkg::ST_ERR;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_ZCHK;
        end
      end
      S_ZCHK: begin
        if (stat.zmod) begin
          st_nxt = crt_pkg::ST_ERR;
          state_nxt = S_OUT;
        end else if (iw == nl) begin
          i_nxt = '0;
          j_nxt = 2'd1;
          state_nxt = (nl == 3'd0) ? S_SINIT : S_GINIT;
        end else begin
          i_nxt = i_r + 2'd1;
        end
      end
      S_GINIT: begin
        cmd.op = crt_pkg::OP_GINIT;
        state_nxt = S_GTEST;
      end
      S_GTEST: begin
        if (stat.rb_zero) begin
          if (!stat.ra_one) begin
            st_nxt = crt_pkg::ST_COPRIME;
            state_nxt = S_OUT;
          end else if (jw == nl) begin
            if (iw + 3'd2 <= nl) begin
              i_nxt = i_r + 2'd1;
              j_nxt = i_r + 2'd2;
              state_nxt = S_GINIT;
            end else begin
              i_nxt = '0;
              state_nxt = S_SINIT;
            end
          end else begin
            j_nxt = j_r + 2'd1;
            state_nxt = S_GINIT;
          end
        end else begin
          cmd.op = crt_pkg::OP_DIV_EU;
          state_nxt = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (stat.div_done) begin
          cmd.op = crt_pkg::OP_EU_UPD;
          state_nxt = S_GTEST;
        end
      end
      S_SINIT: begin
        cmd.op = crt_pkg::OP_SINIT;
        i_nxt = '0;
        state_nxt = S_XD;
      end
      S_XD: begin
        cmd.op = crt_pkg::OP_DIV_X;
        state_nxt = S_XW;
      end
      S_XW: begin
        if (stat.div_done) begin
          cmd.op = crt_pkg::OP_SAVE_X;
          state_nxt = S_MD;
        end
      end
      S_MD: begin
        cmd.op = crt_pkg::OP_DIV_M;
        state_nxt = S_MW;
      end
      S_MW: begin
        if (stat.div_done) begin
          cmd.op = crt_pkg::OP_IINIT;
          state_nxt = S_AD;
        end
      end
      S_AD: begin
        cmd.op = crt_pkg::OP_DIV_A;
        state_nxt = S_AW;
      end
      S_AW: begin
        if (stat.div_done) begin
          cmd.op = crt_pkg::OP_SAVE_A;
          state_nxt = S_ITEST;
        end
      end
      S_ITEST: begin
        if (stat.rb_zero) begin
          cmd.op = crt_pkg::OP_DIV_T;
          state_nxt = S_TW;
        end else begin
          cmd.op = crt_pkg::OP_DIV_EU;
          state_nxt = S_IW;
        end
      end
      S_IW: begin
        if (stat.div_done) begin
          cmd.op = crt_pkg::OP_EU_UPD;
          state_nxt = S_ITEST;
        end
      end
      S_TW: begin
        if (stat.div_done) begin
          cmd.op = crt_pkg::OP_MINIT;
          state_nxt = S_MS;
        end
      end
      S_MS: begin
        if (stat.mul_done) begin
          cmd.op = crt_pkg::OP_MFIN;
          if (iw == nl) begin
            st_nxt = crt_pkg::ST_OK;
            state_nxt = S_OUT;
          end else begin
            i_nxt = i_r + 2'd1;
            state_nxt = S_XD;
          end
        end else begin
          cmd.op = crt_pkg::OP_MSTEP;
        end
      end
      S_OUT: begin
        cmd.op = crt_pkg::OP_OUT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r <= '0;
      j_r <= '0;
      st_r <= crt_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      st_r <= st_nxt;
    end
  end
endmodule

@@ rtl/crt_solver.sv @@
// channel   ports                                           handshake
// input     in_remainder, in_modulus, in_last               start & !busy
// result    out_solution, out_combined_modulus, out_status  out_valid, one cycle
//
// an item without last is loaded while busy stays low
// a last item starts solving; an overflow or a zero modulus answers with an error and no division
// otherwise every division runs on one bit-serial divider, which is shared by every
// gcd step, inverse step and residue
// out_valid rises for one cycle as busy falls
// rst_n is synchronous; the receiver cannot stall results
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crt_solver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_remainder,
  input  logic [15:0]        in_modulus,
  input  logic               in_last,
  output logic               out_valid,
  output logic [63:0]        out_solution,
  output logic [63:0]        out_combined_modulus,
  output logic [1:0]         out_status
);
  crt_pkg::cmd_t  cmd;
  crt_pkg::stat_t stat;

  crt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_last),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  crt_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_remainder         (in_remainder),
    .in_modulus           (in_modulus),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_solution         (out_solution),
    .out_combined_modulus (out_combined_modulus),
    .out_status           (out_status)
  );

  `ASSERT_NEXT(a_valid_pulse, out_valid, !out_valid)
  `ASSERT_NOW(a_err_zero, out_valid && out_status != crt_pkg::ST_OK,
              out_solution == 64'd0 && out_combined_modulus == 64'd0)
  `ASSERT_NOW(a_sol_range, out_valid && out_status == crt_pkg::ST_OK,
              out_solution < out_combined_modulus)
  `ASSERT_NEXT(a_plain_load, start && !busy && !in_last, !out_valid && !busy)
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic [63:0] solution;
    logic [63:0] combined_modulus;
    logic [1:0]  status;
  } crt_answer_t;

  class crt_scoreboard;
    logic [31:0] residues[4];
    logic [15:0] moduli[4];
    int          held;
    bit          dropped;
    crt_answer_t pending[$];
    int          errors;

    function new();
      held = 0;
      dropped = 0;
      errors = 0;
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] p, logic [63:0] q);
      logic [63:0] t;
      while (q != 0) begin
        t = p % q;
        p = q;
        q = t;
      end
      return p;
    endfunction

    // extended euclid, returns 0 when no inverse exists
    function automatic bit invert(logic [63:0] v, logic [63:0] m, output logic [63:0] inv);
      longint old_r, r, old_s, s, q, t;
      old_r = v;
      r = m;
      old_s = 1;
      s = 0;
      inv = 0;
      while (r != 0) begin
        q = old_r / r;
        t = old_r - q * r;
        old_r = r;
        r = t;
        t = old_s - q * s;
        old_s = s;
        s = t;
      end
      if (old_r != 1) return 0;
      if (old_s < 0) old_s += longint'(m);
      inv = 64'(old_s) % m;
      return 1;
    endfunction

    function automatic logic [63:0] residue_of(logic [31:0] raw, logic [63:0] m);
      logic [63:0] mag;
      if (!raw[31]) return {32'd0, raw} % m;
      mag = {32'd0, (~raw + 32'd1)};
      if (mag == 0) mag = 64'h8000_0000;
      mag = mag % m;
      return (mag == 0) ? 64'd0 : m - mag;
    endfunction

    function void note_item(logic [31:0] rem, logic [15:0] md, logic lst);
      crt_answer_t ans;
      logic [63:0] prod, total, m, co, inv, a, k, term;
      logic [1:0]  st;
      if (held < crt_pkg::MAX_EQ) begin
        residues[held] = rem;
        moduli[held] = md;
        held++;
      end else begin
        dropped = 1;
      end
      if (!lst) return;
      st = dropped ? crt_pkg::ST_ERR : crt_pkg::ST_OK;
      for (int i = 0; i < held; i++)
        if (st == crt_pkg::ST_OK && moduli[i] == 0) st = crt_pkg::ST_ERR;
      for (int i = 0; i < held; i++)
        for (int j = i + 1; j < held; j++)
          if (st == crt_pkg::ST_OK && gcd64(64'(moduli[i]), 64'(moduli[j])) != 1)
            st = crt_pkg::ST_COPRIME;
      prod = 1;
      total = 0;
      if (st == crt_pkg::ST_OK) begin
        for (int i = 0; i < held; i++) prod = prod * 64'(moduli[i]);
        for (int i = 0; i < held; i++) begin
          if (st == crt_pkg::ST_OK) begin
            m = 64'(moduli[i]);
            co = prod / m;
            if (!invert(co % m, m, inv)) begin
              st = crt_pkg::ST_COPRIME;
            end else begin
              a = residue_of(residues[i], m);
              k = (a * inv) % m;
              term = co * k;
              if (term >= prod - total) total = term - (prod - total);
              else total = total + term;
            end
          end
        end
      end
      if (st != crt_pkg::ST_OK) begin
        total = 0;
        prod = 0;
      end
      ans.solution = total;
      ans.combined_modulus = prod;
      ans.status = st;
      pending.push_back(ans);
      held = 0;
      dropped = 0;
    endfunction

    function void check_answer(logic [63:0] sol, logic [63:0] cm, logic [1:0] st);
      crt_answer_t ans;
      if (pending.size() == 0) begin
        $error("unexpected result: solution %0d", sol);
        errors++;
        return;
      end
      ans = pending.pop_front();
      if (sol !== ans.solution) begin
        $error("solution: expected %0d, got %0d", ans.solution, sol);
        errors++;
      end
      if (cm !== ans.combined_modulus) begin
        $error("combined_modulus: expected %0d, got %0d", ans.combined_modulus, cm);
        errors++;
      end
      if (st !== ans.status) begin
        $error("status: expected %0d, got %0d", ans.status, st);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic signed [31:0] in_remainder = 0;
  logic [15:0]        in_modulus = 0;
  logic               in_last = 0;
  logic               out_valid;
  logic [63:0]        out_solution;
  logic [63:0]        out_combined_modulus;
  logic [1:0]         out_status;

  crt_scoreboard sb = new();
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  always #1 clk = ~clk;

  crt_solver i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_remainder(in_remainder), .in_modulus(in_modulus), .in_last(in_last),
    .out_valid(out_valid), .out_solution(out_solution),
    .out_combined_modulus(out_combined_modulus), .out_status(out_status)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid)
      sb.check_answer(out_solution, out_combined_modulus, out_status);
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 2) == 0) n = 0;
    else if ($urandom_range(0, 19) == 0) n = $urandom_range(20, 300);
    else n = $urandom_range(1, 4);
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(logic [31:0] rem, logic [15:0] md, logic lst, bit gaps);
    if (gaps) idle_gap();
    start <= 1;
    in_remainder <= rem;
    in_modulus <= md;
    in_last <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(rem, md, lst);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] any_remainder();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_modulus();
    case ($urandom_range(0, 9))
      0: return 16'hffff;
      1: return 16'd1;
      2: return 16'd0;
      3: return 16'($urandom_range(2, 30));
      default: return 16'($urandom_range(2, 65535));
    endcase
  endfunction

  // usually picks a modulus coprime with those already in the set, but sometimes keeps a shared factor or a zero
  task automatic send_set(int n, bit gaps);
    logic [15:0] mods[4];
    logic [15:0] md;
    int tries;
    for (int i = 0; i < n; i++) begin
      tries = 0;
      do begin
        md = pick_modulus();
        tries++;
        for (int j = 0; j < i; j++)
          if (sb.gcd64(64'(md), 64'(mods[j])) != 1 && tries < 30 && $urandom_range(0, 9) != 0)
            md = 0;
      end while (md == 0 && tries < 30 && $urandom_range(0, 19) != 0);
      mods[i] = md;
      send_item(any_remainder(), md, i == n - 1, gaps);
    end
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed sets
    send_item(32'd2, 16'd3, 0, 0);
    send_item(32'd3, 16'd5, 0, 0);
    send_item(32'd2, 16'd7, 1, 0);
    send_item(32'h8000_0000, 16'hffff, 0, 0);
    send_item(32'h7fff_ffff, 16'hfffe, 0, 0);
    send_item(32'hffff_ffff, 16'hfffd, 0, 0);
    send_item(-32'sd5, 16'hfffb, 1, 0);
    send_item(32'd9, 16'd1, 1, 0);
    send_item(32'd4, 16'd6, 0, 0);
    send_item(32'd1, 16'd4, 1, 0);
    send_item(32'd4, 16'd0, 0, 0);
    send_item(32'd1, 16'd4, 1, 0);
    send_item(32'd0, 16'd0, 0, 0);
    send_item(32'd0, 16'd6, 1, 0);
    for (int i = 0; i < 5; i++) send_item(32'd1, 16'(1 + 2 * i), i == 4, 0);
    send_item(-32'sd1, 16'd1, 0, 0);
    send_item(32'd0, 16'h8000, 1, 0);
    drain();
    // random sets
    for (int k = 0; k < 180; k++) begin
      if (k == 90) drain();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
      send_set(n, 1);
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ crt_solver.f @@
+incdir+rtl
rtl/crt_pkg.sv
rtl/crt_div.sv
rtl/crt_dp.sv
rtl/crt_ctrl.sv
rtl/crt_solver.sv
bench/tb_top.sv
